// ===== rtl/msdlm_pkg.sv =====
// ----------------------------------------------------------------------------
// msdlm_pkg
// Shared types and constants of the MAVLink stream deframer and link monitor.
// ----------------------------------------------------------------------------
package msdlm_pkg;

   localparam logic [7:0]  MAGIC_V2       = 8'hFD;
   localparam logic [7:0]  MAGIC_V1       = 8'hFE;
   localparam logic [23:0] MSG_HEARTBEAT  = 24'd0;
   localparam logic [23:0] MSG_ACK        = 24'd77;
   localparam logic [8:0]  SIG_BYTES      = 9'd13;
   localparam logic [8:0]  HDR_LEN_V2     = 9'd10;
   localparam logic [8:0]  HDR_LEN_V1     = 9'd6;
   localparam logic [8:0]  CHECKSUM_BYTES = 9'd2;
   localparam logic [7:0]  ACK_MIN_LEN    = 8'd3;

   localparam logic [7:0]  OWN_SYSTEM_ID_RESET    = 8'd255;
   localparam logic [7:0]  OWN_COMPONENT_ID_RESET = 8'd190;
   localparam logic [15:0] TIMEOUT_TICKS_RESET    = 16'd3000;

   typedef enum logic [1:0] {
      CSR_OWN_SYSTEM_ID    = 2'd0,
      CSR_OWN_COMPONENT_ID = 2'd1,
      CSR_TIMEOUT_TICKS    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_PAYLOAD   = 2'd0,
      EV_FRAME     = 2'd1,
      EV_LINK_DOWN = 2'd2
   } event_type;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_TAIL    = 2'd3
   } phase_type;

   typedef struct packed {
      logic        emit_payload;
      logic        emit_frame;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [23:0] message_id;
      logic [7:0]  system_id;
      logic [7:0]  component_id;
      logic [7:0]  payload_length;
      logic        ack_valid;
      logic [15:0] ack_command;
      logic [7:0]  ack_result;
      logic        heartbeat_valid;
   } parse_result_type;

   typedef struct packed {
      logic link_up;
      logic link_down;
   } link_status_type;

endpackage

// ===== rtl/msdlm_parser.sv =====
// ----------------------------------------------------------------------------
// msdlm_parser
// Byte-level frame parser: magic hunt, header decode, payload pass-through,
// checksum and signature skip, and frame-end report.
// ----------------------------------------------------------------------------
module msdlm_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take_byte,
   input  logic [7:0]                  rx_byte,
   input  logic [7:0]                  own_system_id,
   input  logic [7:0]                  own_component_id,
   output msdlm_pkg::parse_result_type result
);
   import msdlm_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        is_v2_ff, is_v2_in;
   logic [7:0]  frame_len_ff, frame_len_in;
   logic [8:0]  byte_count_ff, byte_count_in;
   logic        signed_ff, signed_in;
   logic [7:0]  sys_ff, sys_in;
   logic [7:0]  comp_ff, comp_in;
   logic [23:0] msgid_ff, msgid_in;
   logic [23:0] ack_bytes_ff, ack_bytes_in;

   logic [8:0]  hdr_len;
   logic [8:0]  count_inc;
   logic [8:0]  payload_pos;
   logic [7:0]  payload_idx;
   logic [8:0]  frame_end;
   logic        own_frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         is_v2_ff      <= 1'b0;
         frame_len_ff  <= 8'd0;
         byte_count_ff <= 9'd0;
         signed_ff     <= 1'b0;
         sys_ff        <= 8'd0;
         comp_ff       <= 8'd0;
         msgid_ff      <= 24'd0;
         ack_bytes_ff  <= 24'd0;
      end else if (take_byte) begin
         phase_ff      <= phase_in;
         is_v2_ff      <= is_v2_in;
         frame_len_ff  <= frame_len_in;
         byte_count_ff <= byte_count_in;
         signed_ff     <= signed_in;
         sys_ff        <= sys_in;
         comp_ff       <= comp_in;
         msgid_ff      <= msgid_in;
         ack_bytes_ff  <= ack_bytes_in;
      end
   end

   assign hdr_len     = is_v2_ff ? HDR_LEN_V2 : HDR_LEN_V1;
   assign count_inc   = byte_count_ff + 9'd1;
   assign payload_pos = byte_count_ff - hdr_len;
   assign payload_idx = payload_pos[7:0];
   assign frame_end   = hdr_len + {1'b0, frame_len_ff} + CHECKSUM_BYTES
                        + (signed_ff ? SIG_BYTES : 9'd0);
   assign own_frame   = (sys_ff == own_system_id) && (comp_ff == own_component_id);

   always_comb begin
      phase_in      = phase_ff;
      is_v2_in      = is_v2_ff;
      frame_len_in  = frame_len_ff;
      byte_count_in = byte_count_ff;
      signed_in     = signed_ff;
      sys_in        = sys_ff;
      comp_in       = comp_ff;
      msgid_in      = msgid_ff;
      ack_bytes_in  = ack_bytes_ff;
      result        = '0;

      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == MAGIC_V2 || rx_byte == MAGIC_V1) begin
               is_v2_in      = (rx_byte == MAGIC_V2);
               frame_len_in  = 8'd0;
               signed_in     = 1'b0;
               sys_in        = 8'd0;
               comp_in       = 8'd0;
               msgid_in      = 24'd0;
               ack_bytes_in  = 24'd0;
               byte_count_in = 9'd1;
               phase_in      = PH_HEADER;
            end
         end
         PH_HEADER: begin
            if (byte_count_ff == 9'd1) begin
               frame_len_in = rx_byte;
            end else if (is_v2_ff) begin
               if (byte_count_ff == 9'd2) signed_in = rx_byte[0];
               if (byte_count_ff == 9'd5) sys_in = rx_byte;
               if (byte_count_ff == 9'd6) comp_in = rx_byte;
               if (byte_count_ff == 9'd7) msgid_in[7:0] = rx_byte;
               if (byte_count_ff == 9'd8) msgid_in[15:8] = rx_byte;
               if (byte_count_ff == 9'd9) msgid_in[23:16] = rx_byte;
            end else begin
               if (byte_count_ff == 9'd3) sys_in = rx_byte;
               if (byte_count_ff == 9'd4) comp_in = rx_byte;
               if (byte_count_ff == 9'd5) msgid_in = {16'd0, rx_byte};
            end
            byte_count_in = count_inc;
            if (count_inc >= hdr_len) begin
               phase_in = (frame_len_in != 8'd0) ? PH_PAYLOAD : PH_TAIL;
            end
         end
         PH_PAYLOAD: begin
            if (payload_idx == 8'd0) ack_bytes_in[7:0] = rx_byte;
            if (payload_idx == 8'd1) ack_bytes_in[15:8] = rx_byte;
            if (payload_idx == 8'd2) ack_bytes_in[23:16] = rx_byte;
            result.emit_payload   = 1'b1;
            result.data_byte      = rx_byte;
            result.byte_index     = payload_idx;
            result.message_id     = msgid_ff;
            result.system_id      = sys_ff;
            result.component_id   = comp_ff;
            result.payload_length = frame_len_ff;
            byte_count_in = count_inc;
            if ({1'b0, payload_idx} + 9'd1 >= {1'b0, frame_len_ff}) begin
               phase_in = PH_TAIL;
            end
         end
         PH_TAIL: begin
            byte_count_in = count_inc;
            if (count_inc >= frame_end) begin
               // Last checksum or signature byte closes the frame.
               result.emit_frame     = 1'b1;
               result.message_id     = msgid_ff;
               result.system_id      = sys_ff;
               result.component_id   = comp_ff;
               result.payload_length = frame_len_ff;
               if (msgid_ff == MSG_HEARTBEAT) begin
                  result.heartbeat_valid = !own_frame;
               end else if (msgid_ff == MSG_ACK && frame_len_ff >= ACK_MIN_LEN) begin
                  result.ack_valid   = 1'b1;
                  result.ack_command = ack_bytes_ff[15:0];
                  result.ack_result  = ack_bytes_ff[23:16];
               end
               phase_in = PH_HUNT;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

endmodule

// ===== rtl/msdlm_link.sv =====
// ----------------------------------------------------------------------------
// msdlm_link
// Heartbeat link monitor: quiet-time counter and connected flag.
// ----------------------------------------------------------------------------
module msdlm_link (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tick,
   input  logic                       heartbeat,
   input  logic [15:0]                timeout_ticks,
   output msdlm_pkg::link_status_type status
);
   import msdlm_pkg::*;

   logic        heard_ff, heard_in;
   logic        connected_ff, connected_in;
   logic [15:0] quiet_ff, quiet_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         heard_ff     <= 1'b0;
         connected_ff <= 1'b0;
         quiet_ff     <= 16'd0;
      end else begin
         heard_ff     <= heard_in;
         connected_ff <= connected_in;
         quiet_ff     <= quiet_in;
      end
   end

   always_comb begin
      heard_in         = heard_ff;
      connected_in     = connected_ff;
      quiet_in         = quiet_ff;
      status.link_down = 1'b0;
      if (heartbeat) begin
         heard_in     = 1'b1;
         connected_in = 1'b1;
         quiet_in     = 16'd0;
      end else if (tick && heard_ff) begin
         // The quiet count saturates rather than wrapping back to zero.
         if (quiet_ff != 16'hFFFF) quiet_in = quiet_ff + 16'd1;
         if (connected_ff && quiet_in >= timeout_ticks) begin
            connected_in     = 1'b0;
            status.link_down = 1'b1;
         end
      end
      status.link_up = connected_in;
   end

endmodule

// ===== rtl/mavlink_stream_deframer_link_monitor.sv =====
// ----------------------------------------------------------------------------
// mavlink_stream_deframer_link_monitor
// MAVLink v1/v2 stream deframer with a heartbeat-driven link monitor.
// ----------------------------------------------------------------------------
// The request channel carries one item per transaction: a received stream
// byte (req_kind = 0) or a one-millisecond tick (req_kind = 1). Each item
// gives zero or one transaction on the response channel: a payload byte, a
// frame-complete report with decoded acknowledgment and heartbeat flags, or
// a link-down event. Header, checksum and signature bytes, and ticks that do
// not drop the link, give no response.
// An item is decoded in the cycle it is accepted and its result is held in
// the response register, so rsp_valid rises in the following cycle. One
// item is taken every cycle while the response register is empty or is being
// read in the same cycle; when the receiver stalls, req_ready drops and the
// pending response is held unchanged.
// The csr port writes the own system id, own component id and link timeout;
// it is to be written only while the block is idle; the block does not enforce this.
// A synchronous reset returns the parser to the magic hunt, clears the link
// state and the response valid flag, and loads the register defaults.
// ----------------------------------------------------------------------------
module mavlink_stream_deframer_link_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_res,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_byte_index,
   output logic [23:0] rsp_message_id,
   output logic [7:0]  rsp_system_id,
   output logic [7:0]  rsp_component_id,
   output logic [7:0]  rsp_payload_length,
   output logic        rsp_ack_valid,
   output logic [15:0] rsp_ack_command,
   output logic [7:0]  rsp_ack_result,
   output logic        rsp_heartbeat_valid,
   output logic        rsp_link_up,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   import msdlm_pkg::*;

   logic [7:0]  own_sys_ff;
   logic [7:0]  own_comp_ff;
   logic [15:0] timeout_ff;

   logic             accept;
   logic             take_byte;
   logic             take_tick;
   parse_result_type parse;
   link_status_type  link;
   logic             has_result;

   logic             rsp_valid_ff, rsp_valid_in;
   event_type        event_ff, event_in;
   parse_result_type fields_ff, fields_in;
   logic             link_up_ff, link_up_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_sys_ff  <= OWN_SYSTEM_ID_RESET;
         own_comp_ff <= OWN_COMPONENT_ID_RESET;
         timeout_ff  <= TIMEOUT_TICKS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OWN_SYSTEM_ID:    own_sys_ff  <= csr_write_data[7:0];
            CSR_OWN_COMPONENT_ID: own_comp_ff <= csr_write_data[7:0];
            CSR_TIMEOUT_TICKS:    timeout_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign take_byte = accept && !req_kind;
   assign take_tick = accept && req_kind;

   msdlm_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .take_byte        (take_byte),
      .rx_byte          (req_rx_byte),
      .own_system_id    (own_sys_ff),
      .own_component_id (own_comp_ff),
      .result           (parse)
   );

   msdlm_link u_link (
      .clock         (clock),
      .reset         (reset),
      .tick          (take_tick),
      .heartbeat     (take_byte && parse.heartbeat_valid),
      .timeout_ticks (timeout_ff),
      .status        (link)
   );

   always_comb begin
      has_result = 1'b0;
      event_in   = EV_PAYLOAD;
      fields_in  = '0;
      link_up_in = link.link_up;
      if (take_byte && (parse.emit_payload || parse.emit_frame)) begin
         has_result = 1'b1;
         event_in   = parse.emit_frame ? EV_FRAME : EV_PAYLOAD;
         fields_in  = parse;
      end else if (take_tick && link.link_down) begin
         has_result = 1'b1;
         event_in   = EV_LINK_DOWN;
      end
      rsp_valid_in = has_result || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (has_result) begin
         event_ff   <= event_in;
         fields_ff  <= fields_in;
         link_up_ff <= link_up_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_res       = event_ff;
   assign rsp_data_byte       = fields_ff.data_byte;
   assign rsp_byte_index      = fields_ff.byte_index;
   assign rsp_message_id      = fields_ff.message_id;
   assign rsp_system_id       = fields_ff.system_id;
   assign rsp_component_id    = fields_ff.component_id;
   assign rsp_payload_length  = fields_ff.payload_length;
   assign rsp_ack_valid       = fields_ff.ack_valid;
   assign rsp_ack_command     = fields_ff.ack_command;
   assign rsp_ack_result      = fields_ff.ack_result;
   assign rsp_heartbeat_valid = fields_ff.heartbeat_valid;
   assign rsp_link_up         = link_up_ff;

endmodule

// ===== tb/mavlink_stream_deframer_link_monitor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavlink_stream_deframer_link_monitor_tb
// Self-checking bench for the MAVLink deframer and heartbeat link monitor.
// A short directed table opens the run. Random v1/v2 frames, noise, broken
// frames and tick bursts follow, under several register settings. A
// software copy of the parser and link monitor predicts every response
// transaction but those of hand-typed rows. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module mavlink_stream_deframer_link_monitor_tb;
   import msdlm_pkg::*;

   localparam int CYCLE_LIMIT = 1_500_000;

   typedef struct packed {
      event_type   ev;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [23:0] message_id;
      logic [7:0]  system_id;
      logic [7:0]  component_id;
      logic [7:0]  payload_length;
      logic        ack_valid;
      logic [15:0] ack_command;
      logic [7:0]  ack_result;
      logic        heartbeat_valid;
      logic        link_up;
   } deframer_report_t;

   // One stimulus item; lit marks a row whose response is typed in by hand.
   typedef struct packed {
      logic             kind;
      logic [7:0]       rx_byte;
      logic             lit;
      logic             lit_has;
      deframer_report_t lit_report;
   } stim_row_t;

   typedef logic [11:0][31:0] field_words_t;

   localparam deframer_report_t HB_REPORT = '{EV_FRAME, 8'd0, 8'd0, 24'd0, 8'd1, 8'd1,
      8'd0, 1'b0, 16'd0, 8'd0, 1'b1, 1'b1};
   localparam deframer_report_t ACK_REPORT = '{EV_FRAME, 8'd0, 8'd0, 24'd77, 8'hFF, 8'hBE,
      8'd3, 1'b1, 16'hFFFF, 8'hFF, 1'b0, 1'b1};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_event_res;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_byte_index;
   logic [23:0] rsp_message_id;
   logic [7:0]  rsp_system_id;
   logic [7:0]  rsp_component_id;
   logic [7:0]  rsp_payload_length;
   logic        rsp_ack_valid;
   logic [15:0] rsp_ack_command;
   logic [7:0]  rsp_ack_result;
   logic        rsp_heartbeat_valid;
   logic        rsp_link_up;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_OWN_SYSTEM_ID;
   logic [15:0] csr_write_data = 16'd0;

   // Predictor copy of the registers and of the parser and link state.
   logic [7:0]  own_sys = OWN_SYSTEM_ID_RESET;
   logic [7:0]  own_comp = OWN_COMPONENT_ID_RESET;
   logic [15:0] link_timeout = TIMEOUT_TICKS_RESET;
   phase_type   rx_phase = PH_HUNT;
   logic        rx_is_v2 = 1'b0;
   logic [7:0]  rx_len = 8'd0;
   logic [8:0]  rx_pos = 9'd0;
   logic        rx_signed = 1'b0;
   logic [7:0]  rx_sys = 8'd0;
   logic [7:0]  rx_comp = 8'd0;
   logic [23:0] rx_msgid = 24'd0;
   logic [23:0] rx_ack = 24'd0;
   logic        link_heard = 1'b0;
   logic        link_connected = 1'b0;
   logic [15:0] link_quiet = 16'd0;

   deframer_report_t pending_reports [$];
   stim_row_t        drive_row = '0;
   int               failures = 0;
   int               items_sent = 0;
   int               burst_left = 0;
   int               stall_mode = 0;
   int               stall_timer = 0;
   int               cycle_count = 0;

   string report_field_names [12] = '{"event_res", "data_byte", "byte_index", "message_id",
      "system_id", "component_id", "payload_length", "ack_valid", "ack_command",
      "ack_result", "heartbeat_valid", "link_up"};

   mavlink_stream_deframer_link_monitor dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_res       (rsp_event_res),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_byte_index      (rsp_byte_index),
      .rsp_message_id      (rsp_message_id),
      .rsp_system_id       (rsp_system_id),
      .rsp_component_id    (rsp_component_id),
      .rsp_payload_length  (rsp_payload_length),
      .rsp_ack_valid       (rsp_ack_valid),
      .rsp_ack_command     (rsp_ack_command),
      .rsp_ack_result      (rsp_ack_result),
      .rsp_heartbeat_valid (rsp_heartbeat_valid),
      .rsp_link_up         (rsp_link_up),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advances the predictor by one item and returns 1 when it yields a report.
   function automatic bit deframe_item(input logic kind, input logic [7:0] b,
                                       output deframer_report_t rep);
      logic [8:0] hdr_len;
      logic [8:0] pos;
      logic [7:0] idx;
      rep = '0;
      if (kind) begin
         if (!link_heard) return 1'b0;
         if (link_quiet != 16'hFFFF) link_quiet++;
         if (link_connected && link_quiet >= link_timeout) begin
            link_connected = 1'b0;
            rep.ev = EV_LINK_DOWN;
            return 1'b1;
         end
         return 1'b0;
      end
      hdr_len = rx_is_v2 ? HDR_LEN_V2 : HDR_LEN_V1;
      pos = rx_pos;
      case (rx_phase)
         PH_HUNT: begin
            if (b == MAGIC_V2 || b == MAGIC_V1) begin
               rx_is_v2 = (b == MAGIC_V2);
               rx_len = 8'd0;
               rx_signed = 1'b0;
               rx_sys = 8'd0;
               rx_comp = 8'd0;
               rx_msgid = 24'd0;
               rx_ack = 24'd0;
               rx_pos = 9'd1;
               rx_phase = PH_HEADER;
            end
            return 1'b0;
         end
         PH_HEADER: begin
            if (pos == 9'd1) begin
               rx_len = b;
            end else if (rx_is_v2) begin
               case (pos)
                  9'd2: rx_signed = b[0];
                  9'd5: rx_sys = b;
                  9'd6: rx_comp = b;
                  9'd7: rx_msgid[7:0] = b;
                  9'd8: rx_msgid[15:8] = b;
                  9'd9: rx_msgid[23:16] = b;
                  default: ;
               endcase
            end else begin
               case (pos)
                  9'd3: rx_sys = b;
                  9'd4: rx_comp = b;
                  9'd5: rx_msgid = {16'd0, b};
                  default: ;
               endcase
            end
            rx_pos = pos + 9'd1;
            if (rx_pos >= hdr_len) rx_phase = (rx_len != 8'd0) ? PH_PAYLOAD : PH_TAIL;
            return 1'b0;
         end
         PH_PAYLOAD: begin
            idx = 8'(pos - hdr_len);
            if (idx < 8'd3) rx_ack = rx_ack | (24'(b) << (8 * idx));
            rep.ev = EV_PAYLOAD;
            rep.data_byte = b;
            rep.byte_index = idx;
            rep.message_id = rx_msgid;
            rep.system_id = rx_sys;
            rep.component_id = rx_comp;
            rep.payload_length = rx_len;
            rep.link_up = link_connected;
            rx_pos = pos + 9'd1;
            if ({1'b0, idx} + 9'd1 >= {1'b0, rx_len}) rx_phase = PH_TAIL;
            return 1'b1;
         end
         default: begin
            // Checksum bytes, then the signature when the frame is signed.
            rx_pos = pos + 9'd1;
            if (rx_pos < hdr_len + rx_len + CHECKSUM_BYTES + (rx_signed ? SIG_BYTES : 9'd0))
               return 1'b0;
            rep.ev = EV_FRAME;
            rep.message_id = rx_msgid;
            rep.system_id = rx_sys;
            rep.component_id = rx_comp;
            rep.payload_length = rx_len;
            if (rx_msgid == MSG_HEARTBEAT) begin
               if (!(rx_sys == own_sys && rx_comp == own_comp)) begin
                  link_quiet = 16'd0;
                  link_heard = 1'b1;
                  link_connected = 1'b1;
                  rep.heartbeat_valid = 1'b1;
               end
            end else if (rx_msgid == MSG_ACK && rx_len >= ACK_MIN_LEN) begin
               rep.ack_valid = 1'b1;
               rep.ack_command = rx_ack[15:0];
               rep.ack_result = rx_ack[23:16];
            end
            rep.link_up = link_connected;
            rx_phase = PH_HUNT;
            return 1'b1;
         end
      endcase
   endfunction

   function automatic field_words_t report_words(deframer_report_t r);
      field_words_t w;
      w[0] = 32'(r.ev);
      w[1] = 32'(r.data_byte);
      w[2] = 32'(r.byte_index);
      w[3] = 32'(r.message_id);
      w[4] = 32'(r.system_id);
      w[5] = 32'(r.component_id);
      w[6] = 32'(r.payload_length);
      w[7] = 32'(r.ack_valid);
      w[8] = 32'(r.ack_command);
      w[9] = 32'(r.ack_result);
      w[10] = 32'(r.heartbeat_valid);
      w[11] = 32'(r.link_up);
      return w;
   endfunction

   function automatic void compare_report(deframer_report_t want, deframer_report_t got);
      field_words_t e;
      field_words_t a;
      e = report_words(want);
      a = report_words(got);
      for (int i = 0; i < 12; i++) begin
         if (e[i] !== a[i]) begin
            $error("%s: expected 0x%0h, actual 0x%0h", report_field_names[i], e[i], a[i]);
            failures++;
         end
      end
   endfunction

   function automatic stim_row_t free_row(logic kind, logic [7:0] b);
      stim_row_t r;
      r = '0;
      r.kind = kind;
      r.rx_byte = b;
      return r;
   endfunction

   function automatic stim_row_t typed_row(logic kind, logic [7:0] b, logic has,
                                           deframer_report_t rep);
      stim_row_t r;
      r = free_row(kind, b);
      r.lit = 1'b1;
      r.lit_has = has;
      r.lit_report = rep;
      return r;
   endfunction

   // Checks response transactions, then predicts the request accepted at this edge.
   always @(posedge clock) begin
      deframer_report_t predicted;
      deframer_report_t observed;
      bit produces;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            observed = '{event_type'(rsp_event_res), rsp_data_byte, rsp_byte_index,
               rsp_message_id, rsp_system_id, rsp_component_id, rsp_payload_length,
               rsp_ack_valid, rsp_ack_command, rsp_ack_result, rsp_heartbeat_valid,
               rsp_link_up};
            if (pending_reports.size() == 0) begin
               $error("response transaction with none outstanding, event %0d",
                      rsp_event_res);
               failures++;
            end else begin
               compare_report(pending_reports.pop_front(), observed);
            end
         end
         if (req_valid && req_ready) begin
            produces = deframe_item(req_kind, req_rx_byte, predicted);
            if (drive_row.lit) begin
               produces = drive_row.lit_has;
               predicted = drive_row.lit_report;
            end
            if (produces) pending_reports.push_back(predicted);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // The receiver switches at random between four stall patterns.
   always @(negedge clock) begin
      if (stall_timer == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_timer = $urandom_range(40, 250);
      end
      stall_timer--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (stall_timer % 5) != 0;
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // Sends one item in bursts of random length, with a random gap before most bursts.
   task automatic send_item(input stim_row_t row, input bit counts);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 6);
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid = 1'b1;
      req_kind = row.kind;
      req_rx_byte = row.rx_byte;
      drive_row = row;
      do @(posedge clock); while (!req_ready);
      if (counts) items_sent++;
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      case (idx)
         CSR_OWN_SYSTEM_ID: own_sys = value[7:0];
         CSR_OWN_COMPONENT_ID: own_comp = value[7:0];
         default: link_timeout = value;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Builds one well-formed frame. A negative pick lets the length or the message
   // class be drawn at random; message class 0 is a foreign heartbeat.
   task automatic send_frame(input int len_pick, input int class_pick);
      logic [7:0]  frame_bytes [$];
      logic [7:0]  sys;
      logic [7:0]  comp;
      logic [23:0] msgid;
      bit          v2;
      bit          signed_f;
      int          sel;
      int          len;
      v2 = $urandom_range(0, 1);
      sel = (class_pick >= 0) ? class_pick : $urandom_range(0, 9);
      sys = 8'($urandom);
      comp = 8'($urandom);
      len = $urandom_range(0, 10);
      if (v2) msgid = ($urandom_range(0, 7) == 0) ? 24'hFFFFFF : 24'($urandom);
      else msgid = ($urandom_range(0, 7) == 0) ? 24'hFF : 24'($urandom_range(0, 255));
      if (sel < 3) begin
         msgid = MSG_HEARTBEAT;
         if (sys == own_sys && comp == own_comp) comp = comp ^ 8'h01;
      end else if (sel == 3) begin
         msgid = MSG_HEARTBEAT;
         sys = own_sys;
         comp = own_comp;
      end else if (sel < 6) begin
         msgid = MSG_ACK;
         len = $urandom_range(0, 6);
      end
      if (len_pick >= 0) len = len_pick;
      signed_f = v2 && ($urandom_range(0, 3) == 0);
      if (v2) begin
         frame_bytes = '{MAGIC_V2, 8'(len), {7'($urandom), signed_f}, 8'($urandom),
            8'($urandom), sys, comp, msgid[7:0], msgid[15:8], msgid[23:16]};
      end else begin
         frame_bytes = '{MAGIC_V1, 8'(len), 8'($urandom), sys, comp, msgid[7:0]};
      end
      // A magic value inside the payload is plain data.
      repeat (len) begin
         if ($urandom_range(0, 7) == 0)
            frame_bytes.push_back($urandom_range(0, 1) ? MAGIC_V2 : MAGIC_V1);
         else
            frame_bytes.push_back(8'($urandom));
      end
      repeat (signed_f ? 15 : 2) frame_bytes.push_back(8'($urandom));
      foreach (frame_bytes[i]) begin
         if ($urandom_range(0, 15) == 0) send_item(free_row(1'b1, 8'($urandom)), 1'b1);
         send_item(free_row(1'b0, frame_bytes[i]), 1'b1);
      end
   endtask

   task automatic run_link_traffic(input int n_items);
      int target;
      int pick;
      int count;
      target = items_sent + n_items;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         count = $urandom_range(1, 12);
         if (pick < 65) begin
            send_frame(-1, -1);
         end else if (pick < 73) begin
            // Line noise: not counted, since the hunt usually drops it.
            repeat (count % 5) send_item(free_row(1'b0, 8'($urandom)), 1'b0);
         end else if (pick < 90) begin
            repeat (count) send_item(free_row(1'b1, 8'($urandom)), 1'b1);
         end else begin
            // Truncated frame: the parser keeps counting into whatever follows.
            send_item(free_row(1'b0, $urandom_range(0, 1) ? MAGIC_V2 : MAGIC_V1), 1'b1);
            repeat (count) send_item(free_row(1'b0, 8'($urandom)), 1'b1);
         end
      end
   endtask

   initial begin
      stim_row_t directed_rows [$];
      directed_rows = '{
         typed_row(1'b1, 8'h00, 1'b0, '0),
         typed_row(1'b0, 8'h00, 1'b0, '0),
         typed_row(1'b0, 8'hFF, 1'b0, '0),
         // v1 heartbeat from system 1, component 1, empty payload
         free_row(1'b0, MAGIC_V1), free_row(1'b0, 8'h00), free_row(1'b0, 8'h5A),
         free_row(1'b0, 8'h01), free_row(1'b0, 8'h01), free_row(1'b0, 8'h00),
         free_row(1'b0, 8'hFF), typed_row(1'b0, 8'h00, 1'b1, HB_REPORT),
         free_row(1'b1, 8'hFF),
         // v2 command acknowledgment with all-ones payload
         free_row(1'b0, MAGIC_V2), free_row(1'b0, 8'h03), free_row(1'b0, 8'h00),
         free_row(1'b0, 8'h00), free_row(1'b0, 8'h80), free_row(1'b0, 8'hFF),
         free_row(1'b0, 8'hBE), free_row(1'b0, 8'd77), free_row(1'b0, 8'h00),
         free_row(1'b0, 8'h00), free_row(1'b0, 8'hFF), free_row(1'b0, 8'hFF),
         free_row(1'b0, 8'hFF), free_row(1'b0, 8'h00),
         typed_row(1'b0, 8'h00, 1'b1, ACK_REPORT)
      };
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i], 1'b1);
      send_frame(255, -1);
      run_link_traffic(130);
      drain_responses();

      // Zero timeout: the first tick after a heartbeat drops the link.
      write_register(CSR_OWN_SYSTEM_ID, 16'd0);
      write_register(CSR_OWN_COMPONENT_ID, 16'd0);
      write_register(CSR_TIMEOUT_TICKS, 16'd0);
      run_link_traffic(120);
      drain_responses();

      write_register(CSR_OWN_SYSTEM_ID, 16'd255);
      write_register(CSR_OWN_COMPONENT_ID, 16'd255);
      write_register(CSR_TIMEOUT_TICKS, 16'd1);
      run_link_traffic(120);
      drain_responses();

      write_register(CSR_OWN_SYSTEM_ID, 16'($urandom_range(0, 255)));
      write_register(CSR_OWN_COMPONENT_ID, 16'($urandom_range(0, 255)));
      write_register(CSR_TIMEOUT_TICKS, 16'd8);
      send_frame(255, 0);
      run_link_traffic(150);
      drain_responses();

      // Longest timeout: enlarging it never revives the link, and a heartbeat
      // then survives a run of quiet ticks. Shrinking the timeout to the
      // quiet count drops the link at the next tick.
      write_register(CSR_TIMEOUT_TICKS, 16'hFFFF);
      repeat (5) send_item(free_row(1'b1, 8'($urandom)), 1'b1);
      send_frame(-1, 0);
      repeat (40) send_item(free_row(1'b1, 8'($urandom)), 1'b1);
      drain_responses();
      write_register(CSR_TIMEOUT_TICKS, 16'd40);
      repeat (3) send_item(free_row(1'b1, 8'($urandom)), 1'b1);
      drain_responses();

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
